// ----- rtl/core/syrk_pkg.sv -----
package syrk_pkg;

  parameter int unsigned MaxDimDefault   = 16;
  parameter int unsigned ElemBitsDefault = 32;
  parameter int unsigned FracBits        = 16;

  localparam int unsigned OpBits  = 3;
  localparam int unsigned IdxBits = 4;
  localparam int unsigned FldBits = 32;
  localparam int unsigned DimBits = 5;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [OpBits-1:0] {
    OP_WRITE_A = 3'd0,
    OP_WRITE_B = 3'd1,
    OP_WRITE_C = 3'd2,
    OP_RUN     = 3'd3,
    OP_READ_C  = 3'd4
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_INNER  = 3'd2,
    REG_SCALEA = 3'd3,
    REG_SCALEB = 3'd4,
    REG_FLIPA  = 3'd5,
    REG_FLIPB  = 3'd6
  } reg_e;

endpackage

// ----- rtl/core/syrk_upper_triangle_update_top.sv -----
// Symmetric rank-k update of the upper triangle of C in Q16.16. A C read
// passes through a memory read register and then the output register, and
// input is stalled meanwhile. With the dimensions clamped to MaxDim, a run
// visits each (i, j) with i below min(rows, cols) and i <= j < cols, and
// does nothing when inner is zero: for each (i, j) the C read is issued
// (S_CLOAD), each multiply-accumulate step reads A and B from their memories
// (S_AB), then does three chained fixed-point multiplies through one shared
// multiplier, one per cycle (S_M1 to S_M3), and accumulates into a register,
// and S_CWR writes the finished C entry back. Results wait in an output
// register; input is stalled while any request is in progress.
module syrk_upper_triangle_update_top #(
  parameter int unsigned MaxDim   = syrk_pkg::MaxDimDefault,
  parameter int unsigned ElemBits = syrk_pkg::ElemBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [syrk_pkg::OpBits-1:0]        op_i,
  input  logic [syrk_pkg::IdxBits-1:0]       row_index_i,
  input  logic [syrk_pkg::IdxBits-1:0]       col_index_i,
  input  logic signed [syrk_pkg::FldBits-1:0] elem_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [syrk_pkg::FldBits-1:0] c_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [syrk_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [syrk_pkg::FldBits-1:0]       cfg_data_i
);

  localparam int unsigned AW    = $clog2(MaxDim);
  localparam int unsigned Depth = MaxDim * MaxDim;
  localparam int unsigned CW    = $clog2(MaxDim + 1);
  localparam int unsigned W     = ElemBits;
  localparam int unsigned PW    = 2 * W;
  localparam int unsigned FW    = syrk_pkg::FldBits;
  localparam int unsigned IW    = syrk_pkg::IdxBits;

  localparam logic signed [W-1:0] EMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] EMin = {1'b1, {(W-1){1'b0}}};

  localparam logic signed [FW+W-1:0] OutMax = (FW + W)'($signed({1'b0, {(FW-1){1'b1}}}));
  localparam logic signed [FW+W-1:0] OutMin = (FW + W)'($signed({1'b1, {(FW-1){1'b0}}}));

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_CLOAD = 8'b0000_0100,
    S_AB    = 8'b0000_1000,
    S_M1    = 8'b0001_0000,
    S_M2    = 8'b0010_0000,
    S_M3    = 8'b0100_0000,
    S_CWR   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [W-1:0] mem_a [Depth];
  logic [W-1:0] mem_b [Depth];
  logic [W-1:0] mem_c [Depth];

  logic [syrk_pkg::DimBits-1:0] rows_q, cols_q, inner_q;
  logic signed [FW-1:0] scale_a_q, scale_b_q;
  logic flip_a_q, flip_b_q;

  logic [CW-1:0] ni, nj, nk;
  logic [CW-1:0] i_q, j_q, k_q;
  logic signed [W-1:0] acc_q, t_q, a_rd_q, b_rd_q, c_rd_q;
  logic out_valid_q;
  logic signed [FW-1:0] out_q;
  logic rd_inrange_q;

  function automatic logic [CW-1:0] clamp(input logic [syrk_pkg::DimBits-1:0] d);
    logic [CW:0] dd;
    dd = (CW + 1)'(d);
    return (dd > (CW + 1)'(MaxDim)) ? CW'(MaxDim) : CW'(dd);
  endfunction

  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] y);
    logic signed [PW-1:0] p;
    logic [PW-1:0] mag, q;
    logic neg;
    p   = PW'(x) * PW'(y);
    neg = p[PW-1];
    mag = neg ? (~p + 1'b1) : p;
    q   = mag >> syrk_pkg::FracBits;
    if (neg) begin
      if (q > PW'({1'b1, {(W-1){1'b0}}})) return EMin;
      return W'(~q + 1'b1);
    end
    if (q > PW'(EMax)) return EMax;
    return W'(q);
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s > (W + 1)'(EMax)) return EMax;
    if (s < (W + 1)'(EMin)) return EMin;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ext(input logic signed [FW-1:0] v);
    logic signed [W+FW-1:0] e;
    e = (W + FW)'(v);
    if (e > (W + FW)'(EMax)) return EMax;
    if (e < (W + FW)'(EMin)) return EMin;
    return e[W-1:0];
  endfunction

  function automatic logic [2*AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return {r[AW-1:0], c[AW-1:0]};
  endfunction

  assign ni = clamp(rows_q);
  assign nj = clamp(cols_q);
  assign nk = clamp(inner_q);

  logic accept;
  logic in_range;
  logic [2*AW-1:0] in_addr;
  logic [CW-1:0] row_ext, col_ext;
  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign row_ext   = CW'(row_index_i);
  assign col_ext   = CW'(col_index_i);
  assign in_range  = ((IW + 1)'(row_index_i) < (IW + 1)'(MaxDim)) &&
                     ((IW + 1)'(col_index_i) < (IW + 1)'(MaxDim));
  assign in_addr   = addr(row_ext, col_ext);
  assign cfg_ready_o = 1'b1;

  // A single multiplier serves all three products of a step.
  logic signed [W-1:0] mul_x, mul_y, mul_r;
  always_comb begin
    mul_x = t_q;
    mul_y = b_rd_q;
    unique case (state_q)
      S_M1:    begin mul_x = ext(scale_a_q); mul_y = a_rd_q; end
      S_M2:    begin mul_x = t_q; mul_y = ext(scale_b_q); end
      default: begin mul_x = t_q; mul_y = b_rd_q; end
    endcase
  end
  assign mul_r = qmul(mul_x, mul_y);

  logic [2*AW-1:0] a_addr, b_addr, c_addr;
  assign a_addr = flip_a_q ? addr(k_q, i_q) : addr(i_q, k_q);
  assign b_addr = flip_b_q ? addr(j_q, k_q) : addr(k_q, j_q);
  assign c_addr = addr(i_q, j_q);

  logic row_has_work;
  assign row_has_work = (i_q < ni) && (i_q < nj);

  // C has one write port, shared by element writes and run write-backs.
  logic c_we;
  logic [2*AW-1:0] c_waddr;
  logic [W-1:0] c_wdata;
  assign c_we    = (state_q == S_CWR) ||
                   (accept && in_range && (op_i == syrk_pkg::OP_WRITE_C));
  assign c_waddr = (state_q == S_CWR) ? c_addr : in_addr;
  assign c_wdata = (state_q == S_CWR) ? acc_q : ext(elem_value_i);

  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      unique case (op_i)
        syrk_pkg::OP_WRITE_A: mem_a[in_addr] <= ext(elem_value_i);
        syrk_pkg::OP_WRITE_B: mem_b[in_addr] <= ext(elem_value_i);
        default: ;
      endcase
    end
    if (c_we) mem_c[c_waddr] <= c_wdata;
    a_rd_q <= mem_a[a_addr];
    b_rd_q <= mem_b[b_addr];
    c_rd_q <= mem_c[(state_q == S_IDLE) ? in_addr : c_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) begin
        if (op_i == syrk_pkg::OP_READ_C) state_d = S_READ;
        else if (op_i == syrk_pkg::OP_RUN) state_d = S_CLOAD;
      end
      S_READ:  state_d = S_IDLE;
      // The C entry is read here and taken into the accumulator on the first step.
      S_CLOAD: begin
        if (!row_has_work) state_d = S_IDLE;
        else if (k_q < nk) state_d = S_AB;
        else state_d = S_IDLE;
      end
      S_AB: state_d = S_M1;
      S_M1: state_d = S_M2;
      S_M2: state_d = S_M3;
      S_M3: state_d = (k_q + 1'b1 < nk) ? S_AB : S_CWR;
      S_CWR: state_d = S_CLOAD;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rows_q      <= '0;
      cols_q      <= '0;
      inner_q     <= '0;
      scale_a_q   <= FW'(65536);
      scale_b_q   <= FW'(65536);
      flip_a_q    <= 1'b0;
      flip_b_q    <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          syrk_pkg::REG_ROWS:   rows_q    <= cfg_data_i[syrk_pkg::DimBits-1:0];
          syrk_pkg::REG_COLS:   cols_q    <= cfg_data_i[syrk_pkg::DimBits-1:0];
          syrk_pkg::REG_INNER:  inner_q   <= cfg_data_i[syrk_pkg::DimBits-1:0];
          syrk_pkg::REG_SCALEA: scale_a_q <= cfg_data_i;
          syrk_pkg::REG_SCALEB: scale_b_q <= cfg_data_i;
          syrk_pkg::REG_FLIPA:  flip_a_q  <= cfg_data_i[0];
          syrk_pkg::REG_FLIPB:  flip_b_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == S_READ) out_valid_q <= 1'b1;
      if (state_q == S_IDLE && accept) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end
      if (state_q == S_CLOAD && !row_has_work) i_q <= '0;
      if (state_q == S_M3) k_q <= k_q + 1'b1;
      if (state_q == S_CWR) begin
        k_q <= '0;
        if (j_q + 1'b1 < nj) begin
          j_q <= j_q + 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
          j_q <= i_q + 1'b1;
        end
      end
    end
  end

  logic signed [FW+W-1:0] rd_wide;
  assign rd_wide = (FW + W)'(c_rd_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) rd_inrange_q <= in_range;
    if (state_q == S_AB && k_q == '0) acc_q <= c_rd_q;
    if (state_q == S_M1 || state_q == S_M2) t_q <= mul_r;
    if (state_q == S_M3) acc_q <= sadd(acc_q, mul_r);
    if (state_q == S_READ) begin
      if (!rd_inrange_q) out_q <= '0;
      else if (rd_wide > OutMax) out_q <= OutMax[FW-1:0];
      else if (rd_wide < OutMin) out_q <= OutMin[FW-1:0];
      else out_q <= rd_wide[FW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign c_value_o   = out_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_read_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> out_valid_o) else $error("read gave no result");
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AB) |-> (k_q < nk)) else $error("inner index out of range");
  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CWR) |-> (j_q >= i_q)) else $error("write below diagonal");

endmodule

// ----- verif/syrk_checker.sv -----
`timescale 1ns / 100ps

module syrk_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [syrk_pkg::OpBits-1:0]         op_i,
  input  logic [syrk_pkg::IdxBits-1:0]        row_index_i,
  input  logic [syrk_pkg::IdxBits-1:0]        col_index_i,
  input  logic signed [syrk_pkg::FldBits-1:0] elem_value_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [syrk_pkg::FldBits-1:0] c_value_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [syrk_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [syrk_pkg::FldBits-1:0]        cfg_data_i,
  output int                                  failures_o,
  output int                                  pending_o
);

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  logic signed [31:0] mat_a [256];
  logic signed [31:0] mat_b [256];
  logic signed [31:0] mat_c [256];
  logic [4:0]         rows_cfg, cols_cfg, inner_cfg;
  logic signed [31:0] scale_a_cfg, scale_b_cfg;
  logic               flip_a_cfg, flip_b_cfg;
  logic signed [31:0] c_expected [$];

  function automatic logic signed [31:0] clamp_q(longint v);
    if (v > QMax) return 32'sh7fffffff;
    if (v < QMin) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Signed division truncates toward zero, which is the rounding wanted here.
  function automatic logic signed [31:0] q_mul(logic signed [31:0] x, logic signed [31:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return clamp_q(p / 65536);
  endfunction

  function automatic int dim_of(logic [4:0] d);
    return (d > 16) ? 16 : int'(d);
  endfunction

  task automatic update_upper();
    int ni, nj, nk;
    logic signed [31:0] av, bv, t;
    ni = dim_of(rows_cfg);
    nj = dim_of(cols_cfg);
    nk = dim_of(inner_cfg);
    for (int i = 0; i < ni; i++) begin
      for (int j = i; j < nj; j++) begin
        for (int k = 0; k < nk; k++) begin
          av = flip_a_cfg ? mat_a[k*16+i] : mat_a[i*16+k];
          bv = flip_b_cfg ? mat_b[j*16+k] : mat_b[k*16+j];
          t = q_mul(q_mul(q_mul(scale_a_cfg, av), scale_b_cfg), bv);
          mat_c[i*16+j] = clamp_q(longint'(mat_c[i*16+j]) + longint'(t));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg = '0;
      cols_cfg = '0;
      inner_cfg = '0;
      scale_a_cfg = 32'sd65536;
      scale_b_cfg = 32'sd65536;
      flip_a_cfg = 1'b0;
      flip_b_cfg = 1'b0;
      c_expected.delete();
      failures_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (syrk_pkg::reg_e'(cfg_index_i))
          syrk_pkg::REG_ROWS:   rows_cfg = cfg_data_i[4:0];
          syrk_pkg::REG_COLS:   cols_cfg = cfg_data_i[4:0];
          syrk_pkg::REG_INNER:  inner_cfg = cfg_data_i[4:0];
          syrk_pkg::REG_SCALEA: scale_a_cfg = cfg_data_i;
          syrk_pkg::REG_SCALEB: scale_b_cfg = cfg_data_i;
          syrk_pkg::REG_FLIPA:  flip_a_cfg = cfg_data_i[0];
          syrk_pkg::REG_FLIPB:  flip_b_cfg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (c_expected.size() == 0) begin
          failures_o++;
          if (failures_o <= 10)
            $display("%0t: unexpected C read request result %0d", $time, c_value_i);
        end else if (c_value_i !== c_expected[0]) begin
          failures_o++;
          if (failures_o <= 10)
            $display("%0t: C read mismatch, expected %0d, got %0d", $time,
                     c_expected[0], c_value_i);
          void'(c_expected.pop_front());
        end else begin
          void'(c_expected.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (syrk_pkg::op_e'(op_i))
          syrk_pkg::OP_WRITE_A: mat_a[{row_index_i, col_index_i}] = elem_value_i;
          syrk_pkg::OP_WRITE_B: mat_b[{row_index_i, col_index_i}] = elem_value_i;
          syrk_pkg::OP_WRITE_C: mat_c[{row_index_i, col_index_i}] = elem_value_i;
          syrk_pkg::OP_RUN:     update_upper();
          syrk_pkg::OP_READ_C:  c_expected.push_back(mat_c[{row_index_i, col_index_i}]);
          default: ;
        endcase
      end
      pending_o = c_expected.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam logic [syrk_pkg::CfgIdxBits-1:0] RegUnused = '1;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid, in_stall;
  logic [syrk_pkg::OpBits-1:0]         op;
  logic [syrk_pkg::IdxBits-1:0]        row_idx, col_idx;
  logic signed [syrk_pkg::FldBits-1:0] elem_val;
  logic                                out_valid, out_stall;
  logic signed [syrk_pkg::FldBits-1:0] c_value;
  logic                                cfg_valid, cfg_ready;
  logic [syrk_pkg::CfgIdxBits-1:0]     cfg_index;
  logic [syrk_pkg::FldBits-1:0]        cfg_data;
  int                                  failures, pending;

  // Mirror of what has been written, so a run or read never touches a stale entry.
  bit   wr_a [256];
  bit   wr_b [256];
  bit   wr_c [256];
  int   n_rows, n_cols, n_inner;
  bit   fa, fb;
  int   burst_left;
  int   settle;
  int   runs_left;
  bit   hold_req;

  syrk_upper_triangle_update_top dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .row_index_i(row_idx), .col_index_i(col_idx), .elem_value_i(elem_val),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .c_value_o(c_value),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  syrk_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .op_i(op), .row_index_i(row_idx), .col_index_i(col_idx), .elem_value_i(elem_val),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .c_value_i(c_value),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .failures_o(failures), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $urandom_range(0, 3 << 17) - (3 << 16);
    endcase
  endfunction

  function automatic int run_cycles();
    int c;
    c = 3;
    for (int i = 0; i < n_rows && i < n_cols; i++)
      c += (n_cols - i) * (4 * n_inner + 3);
    return c + 16;
  endfunction

  task automatic offer(logic [syrk_pkg::OpBits-1:0] o, logic [3:0] r, logic [3:0] c,
                       logic [31:0] v);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    op <= o;
    row_idx <= r;
    col_idx <= c;
    elem_val <= v;
    do @(posedge clk_i); while (in_stall);
    burst_left--;
    case (syrk_pkg::op_e'(o))
      syrk_pkg::OP_WRITE_A: wr_a[{r, c}] = 1'b1;
      syrk_pkg::OP_WRITE_B: wr_b[{r, c}] = 1'b1;
      syrk_pkg::OP_WRITE_C: wr_c[{r, c}] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic offer_write(logic [syrk_pkg::OpBits-1:0] o, int r, int c);
    offer(o, r[3:0], c[3:0], pick_value());
  endtask

  // Writes every A, B and C entry the coming update will read that is still unset.
  task automatic fill_for_run();
    for (int i = 0; i < n_rows && i < n_cols; i++) begin
      for (int j = i; j < n_cols; j++)
        if (!wr_c[i*16+j]) offer_write(syrk_pkg::OP_WRITE_C, i, j);
      for (int k = 0; k < n_inner; k++) begin
        if (fa && !wr_a[k*16+i]) offer_write(syrk_pkg::OP_WRITE_A, k, i);
        if (!fa && !wr_a[i*16+k]) offer_write(syrk_pkg::OP_WRITE_A, i, k);
      end
    end
    if (n_rows > 0) begin
      for (int j = 0; j < n_cols; j++)
        for (int k = 0; k < n_inner; k++) begin
          if (fb && !wr_b[j*16+k]) offer_write(syrk_pkg::OP_WRITE_B, j, k);
          if (!fb && !wr_b[k*16+j]) offer_write(syrk_pkg::OP_WRITE_B, k, j);
        end
    end
  endtask

  task automatic run_update();
    fill_for_run();
    offer(syrk_pkg::OP_RUN, 4'($urandom), 4'($urandom), $urandom);
    settle = run_cycles();
  endtask

  task automatic read_entry();
    int a;
    a = $urandom_range(0, 255);
    for (int t = 0; t < 256 && !wr_c[a]; t++) a = (a + 1) % 256;
    if (!wr_c[a]) offer_write(syrk_pkg::OP_WRITE_C, a / 16, a % 16);
    offer(syrk_pkg::OP_READ_C, 4'(a / 16), 4'(a % 16), $urandom);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    settle = 4;
  endtask

  // All registers in one request stream; valid stays high between them.
  task automatic set_config(int r, int c, int k, logic [31:0] sa, logic [31:0] sb,
                            bit f_a, bit f_b);
    logic [31:0] vals [8];
    logic [syrk_pkg::CfgIdxBits-1:0] idx [8];
    idx = '{syrk_pkg::REG_ROWS, syrk_pkg::REG_COLS, syrk_pkg::REG_INNER,
            syrk_pkg::REG_SCALEA, syrk_pkg::REG_SCALEB, syrk_pkg::REG_FLIPA,
            syrk_pkg::REG_FLIPB, RegUnused};
    vals = '{($urandom & ~32'h1f) | r, ($urandom & ~32'h1f) | c, ($urandom & ~32'h1f) | k,
             sa, sb, ($urandom & ~32'h1) | f_a, ($urandom & ~32'h1) | f_b, $urandom};
    for (int n = 0; n < 8; n++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[n];
      cfg_data <= vals[n];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    n_rows = (r > 16) ? 16 : r;
    n_cols = (c > 16) ? 16 : c;
    n_inner = (k > 16) ? 16 : k;
    fa = f_a;
    fb = f_b;
    runs_left = (run_cycles() > 3000) ? 1 : 6;
  endtask

  task automatic random_phase(int items);
    int sel;
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        offer_write(syrk_pkg::OP_WRITE_A, $urandom_range(0, 15), $urandom_range(0, 15));
      end else if (sel < 40) begin
        offer_write(syrk_pkg::OP_WRITE_B, $urandom_range(0, 15), $urandom_range(0, 15));
      end else if (sel < 55) begin
        offer_write(syrk_pkg::OP_WRITE_C, $urandom_range(0, 15), $urandom_range(0, 15));
      end else if (sel < 60) begin
        offer(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom), $urandom);
      end else if (sel < 66 && runs_left > 0) begin
        runs_left--;
        run_update();
      end else read_entry();
    end
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    op = '0;
    row_idx = '0;
    col_idx = '0;
    elem_val = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    settle = 4;
    hold_req = 1'b0;
    n_rows = 0;
    n_cols = 0;
    n_inner = 0;
    fa = 0;
    fb = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme values, unused ops, and a small run that saturates.
    set_config(2, 3, 2, 32'h00010000, 32'h00010000, 1'b0, 1'b0);
    offer(syrk_pkg::OP_WRITE_C, 4'hf, 4'hf, 32'h80000000);
    offer(syrk_pkg::OP_READ_C, 4'hf, 4'hf, '0);
    offer(syrk_pkg::OP_WRITE_C, 4'h0, 4'hf, 32'h7fffffff);
    offer(syrk_pkg::OP_READ_C, 4'h0, 4'hf, 32'hffffffff);
    offer(3'd5, 4'h3, 4'h3, 32'h12345678);
    offer(3'd7, 4'hf, 4'h0, 32'hffffffff);
    offer(syrk_pkg::OP_WRITE_A, 4'h0, 4'h0, 32'h7fffffff);
    offer(syrk_pkg::OP_WRITE_A, 4'h0, 4'h1, 32'h80000000);
    offer(syrk_pkg::OP_WRITE_B, 4'h0, 4'h0, 32'h7fffffff);
    offer(syrk_pkg::OP_WRITE_B, 4'h1, 4'h0, 32'h00000000);
    offer(syrk_pkg::OP_WRITE_C, 4'h0, 4'h0, 32'h7ff00000);
    run_update();
    offer(syrk_pkg::OP_READ_C, 4'h0, 4'h0, '0);
    offer(syrk_pkg::OP_READ_C, 4'h0, 4'h1, '0);
    offer(syrk_pkg::OP_READ_C, 4'h0, 4'h2, '0);
    offer(syrk_pkg::OP_READ_C, 4'h1, 4'h1, '0);
    offer(syrk_pkg::OP_READ_C, 4'h1, 4'h2, '0);
    wait_idle();

    set_config(0, 0, 0, 32'h00010000, 32'h00010000, 1'b0, 1'b0);
    random_phase(80);
    set_config(3, 2, 4, 32'h00020000, 32'hffff0000, 1'b1, 1'b0);
    hold_req = 1'b1;
    random_phase(80);
    set_config(31, 31, 31, 32'h7fffffff, 32'h80000000, 1'b0, 1'b1);
    random_phase(80);
    set_config(5, 6, 3, 32'h00000000, $urandom, 1'b1, 1'b1);
    random_phase(80);
    set_config(16, 16, 16, $urandom, $urandom, 1'b1, 1'b1);
    random_phase(80);
    for (int p = 0; p < 7; p++) begin
      set_config($urandom_range(0, 6), $urandom_range(0, 7), $urandom_range(0, 5),
                 pick_value(), pick_value(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      if (p == 3) hold_req = 1'b1;
      random_phase(50);
    end

    repeat (20) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: stall patterns, plus a long hold-off when asked for.
  initial begin
    int mode;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin
    #30000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/syrk_pkg.sv
rtl/core/syrk_upper_triangle_update_top.sv
verif/syrk_checker.sv
verif/tb.sv
